// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("invariant failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`endif
`endif

// ===== rtl/gsc_pkg.sv =====
package gsc_pkg;

  // Number of controller slots with their own state.
  localparam int SLOTS = 4;
  localparam int SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Steering divider: one quotient bit per step, bit 15 flags overflow.
  localparam int DivSteps = 16;
  localparam int StepCntW = $clog2(DivSteps);

  localparam logic [14:0] FullScale = 15'h7FFF;
  localparam logic [15:0] NumScale  = 16'd65534;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_STICK_DZ = 2'd0,
    CFG_STEER_DZ = 2'd1,
    CFG_TRIG_THR = 2'd2,
    CFG_COOLDOWN = 2'd3
  } cfg_idx_e;

  localparam logic [14:0] StickDzReset  = 15'd8192;
  localparam logic [14:0] SteerDzReset  = 15'd3932;
  localparam logic [7:0]  TrigThrReset  = 8'd48;
  localparam logic [7:0]  CooldownReset = 8'd60;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic finish;
  } dp_cmd_t;

  // Maps the raw button word onto pad bit positions; bits 0, 7 and 8 are left clear.
  function automatic logic [16:0] remap_buttons(input logic [15:0] raw);
    logic [16:0] pad;
    pad       = '0;
    pad[1]    = raw[12];
    pad[2]    = raw[13];
    pad[3]    = raw[14];
    pad[4]    = raw[15];
    pad[5]    = raw[8];
    pad[6]    = raw[9];
    pad[9]    = raw[4];
    pad[10]   = raw[5];
    pad[11]   = raw[6];
    pad[12]   = raw[7];
    pad[13]   = raw[0];
    pad[14]   = raw[1];
    pad[15]   = raw[2];
    pad[16]   = raw[3];
    return pad;
  endfunction

endpackage

// ===== rtl/gsc_div.sv =====
module gsc_div import gsc_pkg::*; (
  input  logic        clk_i,
  input  logic        start_i,
  input  logic        step_i,
  input  logic [31:0] num_i,
  input  logic [14:0] den_i,
  output logic [15:0] quo_o
);

  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [15:0] quo_q, quo_d;
  logic        fits;

  // Restoring division of num by twice den, most significant quotient bit first.
  assign fits = rem_q >= dvs_q;

  always_comb begin
    rem_d = rem_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    if (start_i) begin
      rem_d = num_i;
      dvs_d = {1'b0, den_i, 1'b0, 15'b0};
      quo_d = '0;
    end else if (step_i) begin
      if (fits) begin
        rem_d = rem_q - dvs_q;
      end
      dvs_d = {1'b0, dvs_q[31:1]};
      quo_d = {quo_q[14:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

// ===== rtl/gsc_datapath.sv =====
module gsc_datapath import gsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic [2:0]  in_user_i,
  input  logic [63:0] in_data_i,
  output logic [3:0]  out_user_o,
  output logic [87:0] out_data_o
);

  // Configuration registers.
  logic [14:0] stick_dz_q;
  logic [14:0] steer_dz_q;
  logic [7:0]  trig_thr_q;
  logic [7:0]  cooldown_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stick_dz_q <= StickDzReset;
      steer_dz_q <= SteerDzReset;
      trig_thr_q <= TrigThrReset;
      cooldown_q <= CooldownReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STICK_DZ: stick_dz_q <= cfg_data_i;
        CFG_STEER_DZ: steer_dz_q <= cfg_data_i;
        CFG_TRIG_THR: trig_thr_q <= cfg_data_i[7:0];
        CFG_COOLDOWN: cooldown_q <= cfg_data_i[7:0];
      endcase
    end
  end

  // Captured input word.
  logic [1:0]  slot_q;
  logic        ok_q;
  logic [15:0] raw_q;
  logic [7:0]  lt_q, rt_q;
  logic [15:0] tx_q, ty_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slot_q <= in_user_i[1:0];
      ok_q   <= in_user_i[2];
      raw_q  <= in_data_i[15:0];
      lt_q   <= in_data_i[23:16];
      rt_q   <= in_data_i[31:24];
      tx_q   <= in_data_i[47:32];
      ty_q   <= in_data_i[63:48];
    end
  end

  // Magnitudes, squares and the steering numerator.
  logic [15:0] xm, ym;
  logic [31:0] xsq, ysq, rsq;
  logic [15:0] diff;
  logic [31:0] prod;
  logic [14:0] den;
  logic [31:0] num;

  assign xm   = tx_q[15] ? (~tx_q + 16'd1) : tx_q;
  assign ym   = ty_q[15] ? (~ty_q + 16'd1) : ty_q;
  assign xsq  = xm * xm;
  assign ysq  = ym * ym;
  assign rsq  = {17'b0, stick_dz_q} * {17'b0, stick_dz_q};
  assign diff = xm - {1'b0, steer_dz_q};
  assign prod = {16'b0, diff} * {16'b0, NumScale};
  assign den  = FullScale - steer_dz_q;
  assign num  = prod + {17'b0, den};

  logic [30:0] xsq_q, ysq_q, rsq_q;
  logic        steer_zero_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      xsq_q        <= xsq[30:0];
      ysq_q        <= ysq[30:0];
      rsq_q        <= rsq[30:0];
      steer_zero_q <= xm <= {1'b0, steer_dz_q};
    end
  end

  logic [15:0] quo;

  gsc_div u_div (
    .clk_i  (clk_i),
    .start_i(cmd_i.mul),
    .step_i (cmd_i.step),
    .num_i  (num),
    .den_i  (den),
    .quo_o  (quo)
  );

  // Per-slot link state.
  logic                conn_q [SLOTS];
  logic [7:0]          cool_q [SLOTS];
  logic [SlotIdxW-1:0] idx;
  logic                in_range, cooling, sampled, connected;

  assign idx       = SlotIdxW'(slot_q);
  assign in_range  = 32'(slot_q) < 32'(SLOTS);
  assign cooling   = in_range && !conn_q[idx] && (cool_q[idx] != 8'd0);
  assign sampled   = in_range && !cooling;
  assign connected = sampled && ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        conn_q[i] <= 1'b0;
        cool_q[i] <= 8'd0;
      end
    end else if (cmd_i.finish && in_range) begin
      if (cooling) begin
        cool_q[idx] <= cool_q[idx] - 8'd1;
      end else if (!ok_q) begin
        conn_q[idx] <= 1'b0;
        cool_q[idx] <= cooldown_q;
      end else begin
        conn_q[idx] <= 1'b1;
      end
    end
  end

  // Result fields of a good poll.
  logic [16:0] pad;
  logic        in_dz;
  logic [15:0] sx, sy;
  logic [14:0] steer_mag;
  logic [15:0] steer;

  always_comb begin
    pad    = remap_buttons(raw_q);
    pad[7] = lt_q > trig_thr_q;
    pad[8] = rt_q > trig_thr_q;
  end

  assign in_dz = ({1'b0, xsq_q} + {1'b0, ysq_q}) < {1'b0, rsq_q};
  assign sx    = in_dz ? 16'd0 : tx_q;
  assign sy    = in_dz ? 16'd0 :
                 (ty_q == 16'h8000) ? 16'h7FFF : (~ty_q + 16'd1);

  // A full-scale deadzone or a quotient past full scale saturates.
  assign steer_mag = ((&steer_dz_q) || quo[15]) ? FullScale : quo[14:0];
  assign steer     = steer_zero_q ? 16'd0 :
                     tx_q[15] ? (~{1'b0, steer_mag} + 16'd1) : {1'b0, steer_mag};

  // Result register.
  logic [3:0]  out_user_q;
  logic [87:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_user_q <= {connected, sampled, slot_q};
      if (connected) begin
        out_data_q <= {7'b0, lt_q, rt_q, steer, sy, sx, pad};
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign out_user_o = out_user_q;
  assign out_data_o = out_data_q;

endmodule

// ===== rtl/gsc_ctrl.sv =====
module gsc_ctrl import gsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  // The result register may be written when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul    = state_q == ST_MUL;
    cmd_o.step   = state_q == ST_DIV;
    cmd_o.finish = (state_q == ST_DONE) && out_free;
  end

  // Next state, step count and result-valid flag.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + StepCntW'(1);
        if (cnt_q == StepCntW'(DivSteps - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/gamepad_slot_conditioner.sv =====
// Conditions one poll of one controller slot per input word.
// Input stream: s_axis_* carries the poll; tuser holds the slot and the poll
// status, tdata the raw buttons, both triggers and both stick axes.
// Output stream: m_axis_* carries exactly one result word per poll: slot,
// sampled and connected flags in tuser, pad buttons, deadzoned stick,
// steering, throttle and brake in tdata.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i writes one of the
// deadzone, threshold and cooldown registers; cfg_ready_o is always high.
// Write configuration only while no poll is in flight.
// Sequence: the edge that accepts the word moves to a multiply state, then the
// 16-step restoring divider does the steering rescale, then a finish state writes
// the result register and raises m_axis_tvalid; s_axis_tready is low meanwhile.
// The result waits in an output register, so a stalled receiver does not
// hold off the next poll; only a second finished result waits for it.
// Reset restores the register defaults and marks every slot disconnected
// with no cooldown pending.
`include "assert_macros.svh"

module gamepad_slot_conditioner import gsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // raw_buttons, left_trigger, right_trigger, thumb_x, thumb_y
  input  logic [2:0]  s_axis_tuser,  // slot, poll_ok
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // pad_buttons, stick_x, stick_y, steer, throttle, brake
  output logic [3:0]  m_axis_tuser,  // out_slot, sampled, connected
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);

  dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // Sequencing of one poll.
  gsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  // Arithmetic, slot state and result register.
  gsc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_user_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .out_user_o (m_axis_tuser),
    .out_data_o (m_axis_tdata)
  );

  // Checks on the sequencing.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `ASSERT_NEXT(a_valid_after_finish, clk_i, rst_ni, cmd.finish, m_axis_tvalid)
  `ASSERT_IMPL(a_finish_into_free, clk_i, rst_ni, cmd.finish, !m_axis_tvalid || m_axis_tready)
  `ASSERT_ALWAYS(a_one_command, clk_i, rst_ni, $onehot0({cmd.load, cmd.mul, cmd.step, cmd.finish}))

endmodule
